### sv/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge once reset is released.
`define RMQ_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("rmq assertion failed");

// Check a property on every rising edge, reset included.
`define RMQ_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("rmq assertion failed");

`endif

### sv/rmq_pkg.sv
`timescale 1ns / 1ps
package rmq_pkg;

  typedef logic [1:0] pick_t;

  // Which quaternion component carries the root term.
  localparam pick_t PICK_W = 2'd0;
  localparam pick_t PICK_X = 2'd1;
  localparam pick_t PICK_Y = 2'd2;
  localparam pick_t PICK_Z = 2'd3;

  localparam int PICK_BITS = 2;
  localparam int LANES     = 3;

endpackage

### sv/rmq_fifo.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
module rmq_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             empty
);
  localparam int AW = $clog2(DEPTH);

  logic [WIDTH-1:0] mem [0:DEPTH-1];
  logic [AW-1:0]    wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [AW:0]      count_r, count_nxt;
  logic             do_push, do_pop;

  assign full    = (count_r == (AW+1)'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= din;
    end
  end

  `RMQ_ASSERT(a_count_bound, clk, rst_n, count_r <= (AW+1)'(DEPTH))
  `RMQ_ASSERT(a_push_fills, clk, rst_n, (push && !full && !pop) |=> !empty)
  `RMQ_ASSERT(a_pop_frees, clk, rst_n, (pop && !empty && !push) |=> !full)
endmodule

### sv/rmq_front.sv
`timescale 1ns / 1ps
module rmq_front import rmq_pkg::*; #(
  parameter int W = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_push,
  output logic                          in_full,
  input  logic signed [W-1:0]           m00, m01, m02,
  input  logic signed [W-1:0]           m10, m11, m12,
  input  logic signed [W-1:0]           m20, m21, m22,
  output logic                          q_push,
  input  logic                          q_full,
  output logic [W+1:0]                  q_rad,
  output logic [LANES*(W+1)-1:0]        q_num,
  output pick_t                         q_pick
);
  localparam int FRAC = W - 2;
  localparam int EW   = W + 3;

  logic                 v_r;
  logic signed [W-1:0]  a_r [0:8];
  logic signed [EW-1:0] e   [0:8];
  logic signed [EW-1:0] one_e, tr, s;
  logic signed [EW-1:0] p0, p1, p2;
  logic                 load;

  assign in_full = v_r && q_full;
  assign load    = !in_full;
  assign q_push  = v_r && !q_full;
  assign one_e   = EW'(1) <<< FRAC;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (load) begin
      v_r <= in_push;
    end
  end

  always_ff @(posedge clk) begin
    if (load && in_push) begin
      a_r[0] <= m00; a_r[1] <= m01; a_r[2] <= m02;
      a_r[3] <= m10; a_r[4] <= m11; a_r[5] <= m12;
      a_r[6] <= m20; a_r[7] <= m21; a_r[8] <= m22;
    end
  end

  always_comb begin
    for (int i = 0; i < 9; i++) begin
      e[i] = EW'(a_r[i]);
    end
    tr = e[0] + e[4] + e[8];
    // Ties fall to the later branch.
    if (tr > 0) begin
      q_pick = PICK_W;
      s  = tr + one_e;
      p0 = e[7] - e[5];
      p1 = e[2] - e[6];
      p2 = e[3] - e[1];
    end else if (e[0] > e[4] && e[0] > e[8]) begin
      q_pick = PICK_X;
      s  = one_e + e[0] - e[4] - e[8];
      p0 = e[7] - e[5];
      p1 = e[1] + e[3];
      p2 = e[2] + e[6];
    end else if (e[4] > e[8]) begin
      q_pick = PICK_Y;
      s  = one_e + e[4] - e[0] - e[8];
      p0 = e[2] - e[6];
      p1 = e[1] + e[3];
      p2 = e[5] + e[7];
    end else begin
      q_pick = PICK_Z;
      s  = one_e + e[8] - e[0] - e[4];
      p0 = e[3] - e[1];
      p1 = e[2] + e[6];
      p2 = e[5] + e[7];
    end
    // Clamp a negative radicand to zero.
    q_rad = (s <= 0) ? '0 : s[W+1:0];
    q_num = {p2[W:0], p1[W:0], p0[W:0]};
  end
endmodule

### sv/rmq_back.sv
`timescale 1ns / 1ps
module rmq_back import rmq_pkg::*; #(
  parameter int W = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   q_empty,
  output logic                   q_pop,
  input  logic [W+1:0]           q_rad,
  input  logic [LANES*(W+1)-1:0] q_num,
  input  pick_t                  q_pick,
  input  logic                   out_full,
  output logic                   out_push,
  output logic [4*W-1:0]         out_data
);
  localparam int FRAC = W - 2;
  localparam int NB   = 2*W - 1;

  // Square root section: one result bit per stage.
  logic [W:0]             sq_v_r;
  logic [W+1:0]           sq_rem_r  [0:W];
  logic [W+1:0]           sq_rem_nxt[0:W];
  logic [W-1:0]           sq_root_r [0:W];
  logic [W-1:0]           sq_root_nxt[0:W];
  logic [2*W-1:0]         sq_rad_r  [0:W];
  logic [LANES*(W+1)-1:0] sq_num_r  [0:W];
  pick_t                  sq_pick_r [0:W];

  // Divider section: three lanes, one quotient bit per stage.
  logic [NB:0]        dv_v_r;
  logic [W:0]         dv_d_r    [0:NB];
  logic [W-1:0]       dv_root_r [0:NB];
  logic [NB-1:0]      dv_a_r    [0:NB][0:LANES-1];
  logic [W+1:0]       dv_rem_r  [0:NB][0:LANES-1];
  logic [W+1:0]       dv_rem_nxt[0:NB][0:LANES-1];
  logic [NB-1:0]      dv_q_r    [0:NB][0:LANES-1];
  logic [NB-1:0]      dv_q_nxt  [0:NB][0:LANES-1];
  logic [LANES-1:0]   dv_neg_r  [0:NB];
  pick_t              dv_pick_r [0:NB];

  logic               en;
  logic [W:0]         num_lane [0:LANES-1];
  logic [W:0]         mag_lane [0:LANES-1];
  logic [W-1:0]       res_lane [0:LANES-1];
  logic [W-1:0]       picked;
  logic [NB-1:0]      qmax, qmin_mag;

  assign en       = !dv_v_r[NB] || !out_full;
  assign q_pop    = en && !q_empty;
  assign out_push = en && dv_v_r[NB];
  assign qmax     = {{(NB-W+1){1'b0}}, {(W-1){1'b1}}};
  assign qmin_mag = qmax + 1'b1;

  always_comb begin
    for (int s = 0; s < W; s++) begin
      logic [W+1:0] rs, trial;
      rs    = {sq_rem_r[s][W-1:0], sq_rad_r[s][2*W-1-2*s -: 2]};
      trial = {sq_root_r[s], 2'b01};
      if (rs >= trial) begin
        sq_rem_nxt[s]  = rs - trial;
        sq_root_nxt[s] = {sq_root_r[s][W-2:0], 1'b1};
      end else begin
        sq_rem_nxt[s]  = rs;
        sq_root_nxt[s] = {sq_root_r[s][W-2:0], 1'b0};
      end
    end
    sq_rem_nxt[W]  = '0;
    sq_root_nxt[W] = '0;
  end

  always_comb begin
    for (int j = 0; j < NB; j++) begin
      for (int l = 0; l < LANES; l++) begin
        logic [W+1:0] rs;
        rs = {dv_rem_r[j][l][W:0], dv_a_r[j][l][NB-1-j]};
        if (rs >= {1'b0, dv_d_r[j]}) begin
          dv_rem_nxt[j][l] = rs - {1'b0, dv_d_r[j]};
          dv_q_nxt[j][l]   = {dv_q_r[j][l][NB-2:0], 1'b1};
        end else begin
          dv_rem_nxt[j][l] = rs;
          dv_q_nxt[j][l]   = {dv_q_r[j][l][NB-2:0], 1'b0};
        end
      end
    end
    for (int l = 0; l < LANES; l++) begin
      dv_rem_nxt[NB][l] = '0;
      dv_q_nxt[NB][l]   = '0;
    end
  end

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      num_lane[l] = sq_num_r[W][l*(W+1) +: W+1];
      mag_lane[l] = num_lane[l][W] ? (~num_lane[l] + 1'b1) : num_lane[l];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_v_r <= '0;
      dv_v_r <= '0;
    end else if (en) begin
      sq_v_r <= {sq_v_r[W-1:0], !q_empty};
      dv_v_r <= {dv_v_r[NB-1:0], sq_v_r[W]};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq_rem_r[0]  <= '0;
      sq_root_r[0] <= '0;
      sq_rad_r[0]  <= {q_rad, {FRAC{1'b0}}};
      sq_num_r[0]  <= q_num;
      sq_pick_r[0] <= q_pick;
      for (int s = 0; s < W; s++) begin
        sq_rem_r[s+1]  <= sq_rem_nxt[s];
        sq_root_r[s+1] <= sq_root_nxt[s];
        sq_rad_r[s+1]  <= sq_rad_r[s];
        sq_num_r[s+1]  <= sq_num_r[s];
        sq_pick_r[s+1] <= sq_pick_r[s];
      end
      dv_d_r[0]    <= {sq_root_r[W], 1'b0};
      dv_root_r[0] <= sq_root_r[W];
      dv_pick_r[0] <= sq_pick_r[W];
      for (int l = 0; l < LANES; l++) begin
        dv_a_r[0][l]   <= {mag_lane[l], {FRAC{1'b0}}};
        dv_rem_r[0][l] <= '0;
        dv_q_r[0][l]   <= '0;
        dv_neg_r[0][l] <= num_lane[l][W];
      end
      for (int j = 0; j < NB; j++) begin
        dv_d_r[j+1]    <= dv_d_r[j];
        dv_root_r[j+1] <= dv_root_r[j];
        dv_pick_r[j+1] <= dv_pick_r[j];
        dv_neg_r[j+1]  <= dv_neg_r[j];
        for (int l = 0; l < LANES; l++) begin
          dv_a_r[j+1][l]   <= dv_a_r[j][l];
          dv_rem_r[j+1][l] <= dv_rem_nxt[j][l];
          dv_q_r[j+1][l]   <= dv_q_nxt[j][l];
        end
      end
    end
  end

  // Saturate, apply sign, drop to zero on a zero divisor.
  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      if (dv_d_r[NB] == '0) begin
        res_lane[l] = '0;
      end else if (!dv_neg_r[NB][l]) begin
        res_lane[l] = (dv_q_r[NB][l] > qmax) ? {1'b0, {(W-1){1'b1}}}
                                             : dv_q_r[NB][l][W-1:0];
      end else begin
        res_lane[l] = (dv_q_r[NB][l] > qmin_mag) ? {1'b1, {(W-1){1'b0}}}
                                                 : (~dv_q_r[NB][l][W-1:0] + 1'b1);
      end
    end
    picked = {1'b0, dv_root_r[NB][W-1:1]};
    unique case (dv_pick_r[NB])
      PICK_W:  out_data = {res_lane[2], res_lane[1], res_lane[0], picked};
      PICK_X:  out_data = {res_lane[2], res_lane[1], picked, res_lane[0]};
      PICK_Y:  out_data = {res_lane[2], picked, res_lane[1], res_lane[0]};
      default: out_data = {picked, res_lane[2], res_lane[1], res_lane[0]};
    endcase
  end
endmodule

### sv/rotation_matrix_to_quaternion.sv
`timescale 1ns / 1ps
// Rotation matrix to quaternion, signed Q1.(DATA_WIDTH-2) fixed point.
// Input queue: drive in_m00..in_m22 with in_push; a matrix is taken on a
// rising edge with in_push high and in_full low.
// Result queue: while out_empty is low, out_quat_w/x/y/z hold the oldest
// quaternion; raise out_pop to take it.
// Throughput: one matrix per cycle, sustained, when the result side pops.
// The accepting edge loads the input register; after it come one classify
// queue slot, DATA_WIDTH+1 square root stages (all but the last give one
// root bit each), 2*DATA_WIDTH divider stages (all but the last give one
// quotient bit each, three lanes) and the result queue.
// The front classifies the branch and forms the radicand and numerators; a
// short queue parts it from the root/divide pipeline, which advances while
// the result queue has room or its last stage holds no result.
// Reset (rst_n low, synchronous) empties both queues and all stages.
// When the receiver stalls, the pipeline holds, then the classify queue and
// the input register fill, and in_full rises.
module rotation_matrix_to_quaternion import rmq_pkg::*; #(
  parameter int DATA_WIDTH = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_push,
  output logic                         in_full,
  input  logic signed [DATA_WIDTH-1:0] in_m00, in_m01, in_m02,
  input  logic signed [DATA_WIDTH-1:0] in_m10, in_m11, in_m12,
  input  logic signed [DATA_WIDTH-1:0] in_m20, in_m21, in_m22,
  output logic                         out_empty,
  input  logic                         out_pop,
  output logic signed [DATA_WIDTH-1:0] out_quat_w,
  output logic signed [DATA_WIDTH-1:0] out_quat_x,
  output logic signed [DATA_WIDTH-1:0] out_quat_y,
  output logic signed [DATA_WIDTH-1:0] out_quat_z
);
  localparam int W      = DATA_WIDTH;
  localparam int QW     = (W+2) + LANES*(W+1) + PICK_BITS;
  localparam int QDEPTH = 4;
  localparam int ODEPTH = 2;

  logic                   f_push, q_full, q_empty, q_pop;
  logic [W+1:0]           f_rad, b_rad;
  logic [LANES*(W+1)-1:0] f_num, b_num;
  pick_t                  f_pick, b_pick;
  logic [QW-1:0]          q_dout;
  logic                   o_push, o_full;
  logic [4*W-1:0]         o_din, o_dout;

  rmq_front #(.W(W)) u_front (
    .clk, .rst_n, .in_push, .in_full,
    .m00(in_m00), .m01(in_m01), .m02(in_m02),
    .m10(in_m10), .m11(in_m11), .m12(in_m12),
    .m20(in_m20), .m21(in_m21), .m22(in_m22),
    .q_push(f_push), .q_full, .q_rad(f_rad), .q_num(f_num), .q_pick(f_pick)
  );

  rmq_fifo #(.WIDTH(QW), .DEPTH(QDEPTH)) u_cls_q (
    .clk, .rst_n, .push(f_push), .din({f_rad, f_num, f_pick}), .full(q_full),
    .pop(q_pop), .dout(q_dout), .empty(q_empty)
  );

  assign {b_rad, b_num, b_pick} = q_dout;

  rmq_back #(.W(W)) u_back (
    .clk, .rst_n, .q_empty, .q_pop, .q_rad(b_rad), .q_num(b_num),
    .q_pick(b_pick), .out_full(o_full), .out_push(o_push), .out_data(o_din)
  );

  rmq_fifo #(.WIDTH(4*W), .DEPTH(ODEPTH)) u_res_q (
    .clk, .rst_n, .push(o_push), .din(o_din), .full(o_full),
    .pop(out_pop), .dout(o_dout), .empty(out_empty)
  );

  assign {out_quat_z, out_quat_y, out_quat_x, out_quat_w} = o_dout;
endmodule
